FILE: design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Implication checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

FILE: design/cvfr_pkg.sv
// Package with word types, command format and the CRC-32 byte step.
`timescale 1ns / 1ps

package cvfr_pkg;

    // Reflected CRC-32 polynomial and the number of trailing CRC bytes.
    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam int          CRC_BYTES  = 4;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

    // Command queue between the front and the back.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_LW    = 3;

    // Input word.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    // Output word.
    typedef struct packed {
        logic        voxel_valid;
        logic [2:0]  voxel_x;
        logic [2:0]  voxel_y;
        logic [2:0]  voxel_z;
        logic [5:0]  red_level;
        logic [5:0]  green_level;
        logic [5:0]  blue_level;
        logic        frame_done;
        logic        frame_ok;
        logic [15:0] message_length;
    } t_out_word;

    // Role of a byte within the message.
    typedef enum logic [1:0] {
        KIND_VOXEL = 2'd0,
        KIND_CRC   = 2'd1,
        KIND_EXTRA = 2'd2
    } t_kind;

    // Classified byte handed from the front to the back.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [2:0]  voxel_x;
        logic [2:0]  voxel_y;
        logic [2:0]  voxel_z;
        logic        len_ok;
        logic [15:0] message_length;
    } t_cmd;

    // Queue status seen by the top level.
    typedef struct packed {
        logic            full;
        logic            not_empty;
        logic [Q_LW-1:0] level;
    } t_q_status;

    // One byte through the reflected CRC-32 register.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h000000, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: design/crc_checked_voxel_frame_receiver_top.sv
// Top level of the CRC-checked voxel frame receiver.
//
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+------------------------
//   input   | in        | i_in_valid / o_in_stall | i_in_word  (t_in_word)
//   output  | out       | o_out_valid/ i_out_stall| o_out_word (t_out_word)
//
// One word is accepted per cycle while the queue has room; it is classified by
// the front, held in a queue entry, and its result is registered after the back
// end's CRC step. Without output stalls the rate is one word per cycle.
// Reset is synchronous and active low and returns the receiver to the start
// of a message. A stalled output fills the four-entry queue before the
// input stalls.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crc_checked_voxel_frame_receiver_top #(
    parameter int SIDE = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  cvfr_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cvfr_pkg::t_out_word o_out_word
);
    import cvfr_pkg::*;

    logic      in_accept;
    logic      pop;
    t_cmd      front_cmd;
    t_cmd      queue_cmd;
    t_q_status q_status;

    // Accept while the queue has room.
    assign o_in_stall = q_status.full;
    assign in_accept  = i_in_valid && !q_status.full;

    cvfr_front #(
        .SIDE (SIDE)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_word   (i_in_word),
        .o_cmd    (front_cmd)
    );

    cvfr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (in_accept),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_cmd    (queue_cmd),
        .o_status (q_status)
    );

    cvfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_status.not_empty),
        .i_cmd       (queue_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // Checks on queue bookkeeping and result consistency.
    `ASSERT_NEVER(a_q_overflow, i_clk, i_rst_n, q_status.level > Q_LW'(Q_DEPTH), "queue level above depth")
    `ASSERT_CLK(a_ok_done, i_clk, i_rst_n, o_out_valid && o_out_word.frame_ok |-> o_out_word.frame_done, "frame_ok without frame_done")
    `ASSERT_CLK(a_voxel_not_ok, i_clk, i_rst_n, o_out_valid && o_out_word.voxel_valid |-> !o_out_word.frame_ok, "voxel word flagged as good frame")
    `ASSERT_CLK(a_len_done, i_clk, i_rst_n, o_out_valid && !o_out_word.frame_done |-> o_out_word.message_length == 16'd0, "length reported before the last word")

endmodule

FILE: design/cvfr_front.sv
// Front end: counts bytes, tracks voxel coordinates and classifies each word.
`timescale 1ns / 1ps

module cvfr_front #(
    parameter int SIDE = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  cvfr_pkg::t_in_word i_word,
    output cvfr_pkg::t_cmd   o_cmd
);
    import cvfr_pkg::*;

    localparam int          CW        = $clog2(SIDE);
    localparam logic [15:0] VOXELS    = 16'(SIDE * SIDE * SIDE);
    localparam logic [15:0] FRAME_LEN = 16'(SIDE * SIDE * SIDE + CRC_BYTES);
    localparam logic [CW-1:0] LAST_C  = CW'(SIDE - 1);

    logic [15:0]   r_count, n_count;
    logic [CW-1:0] r_x, n_x, r_y, n_y, r_z, n_z;
    logic [15:0]   len;
    logic          is_voxel;
    logic          is_crc;
    logic [CW+2:0] x_ext, y_ext, z_ext;

    // Classify the byte by its position in the message.
    assign is_voxel = r_count < VOXELS;
    assign is_crc   = r_count < FRAME_LEN;
    assign len      = (r_count == COUNT_MAX) ? COUNT_MAX : r_count + 16'd1;

    // Coordinates are reported in three bits.
    assign x_ext = {3'b000, r_x};
    assign y_ext = {3'b000, r_y};
    assign z_ext = {3'b000, r_z};

    always_comb begin
        o_cmd.kind           = is_voxel ? KIND_VOXEL : (is_crc ? KIND_CRC : KIND_EXTRA);
        o_cmd.data_byte      = i_word.data_byte;
        o_cmd.last_byte      = i_word.last_byte;
        o_cmd.voxel_x        = x_ext[2:0];
        o_cmd.voxel_y        = y_ext[2:0];
        o_cmd.voxel_z        = z_ext[2:0];
        o_cmd.len_ok         = len == FRAME_LEN;
        o_cmd.message_length = len;
    end

    // Next count and coordinates; the last word of a message starts over.
    always_comb begin
        n_count = r_count;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        if (i_accept) begin
            if (i_word.last_byte) begin
                n_count = '0;
                n_x     = '0;
                n_y     = '0;
                n_z     = '0;
            end else begin
                n_count = len;
                if (is_voxel) begin
                    if (r_x == LAST_C) begin
                        n_x = '0;
                        if (r_y == LAST_C) begin
                            n_y = '0;
                            n_z = r_z + CW'(1);
                        end else begin
                            n_y = r_y + CW'(1);
                        end
                    end else begin
                        n_x = r_x + CW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_x     <= '0;
            r_y     <= '0;
            r_z     <= '0;
        end else begin
            r_count <= n_count;
            r_x     <= n_x;
            r_y     <= n_y;
            r_z     <= n_z;
        end
    end

endmodule

FILE: design/cvfr_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module cvfr_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  cvfr_pkg::t_cmd      i_cmd,
    input  logic                i_pop,
    output cvfr_pkg::t_cmd      o_cmd,
    output cvfr_pkg::t_q_status o_status
);
    import cvfr_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_LW-1:0] r_level;

    // Entry storage; written only at the write pointer.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + Q_LW'(1);
            end else if (i_pop && !i_push) begin
                r_level <= r_level - Q_LW'(1);
            end
        end
    end

    assign o_cmd              = r_mem[r_rd_ptr];
    assign o_status.full      = r_level == Q_LW'(Q_DEPTH);
    assign o_status.not_empty = r_level != '0;
    assign o_status.level     = r_level;

endmodule

FILE: design/cvfr_back.sv
// Back end: runs the CRC, collects the trailer and registers the result word.
`timescale 1ns / 1ps

module cvfr_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  cvfr_pkg::t_cmd       i_cmd,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output cvfr_pkg::t_out_word  o_out_word
);
    import cvfr_pkg::*;

    logic [31:0] r_crc, n_crc;
    logic [31:0] r_rcv, n_rcv;
    logic        r_out_valid;
    t_out_word   r_out, n_out;

    // Take a command whenever the output register is free or being drained.
    assign o_pop = i_cmd_valid && (!r_out_valid || !i_out_stall);

    // Execute one command.
    always_comb begin
        n_crc = r_crc;
        n_rcv = r_rcv;
        n_out = '0;
        case (i_cmd.kind)
            KIND_VOXEL: begin
                n_crc             = crc32_byte(r_crc, i_cmd.data_byte);
                n_out.voxel_valid = 1'b1;
                n_out.voxel_x     = i_cmd.voxel_x;
                n_out.voxel_y     = i_cmd.voxel_y;
                n_out.voxel_z     = i_cmd.voxel_z;
                n_out.red_level   = {i_cmd.data_byte[7:5], 3'b000};
                n_out.green_level = {i_cmd.data_byte[4:2], 3'b000};
                n_out.blue_level  = {i_cmd.data_byte[1:0], 4'b0000};
            end
            KIND_CRC: begin
                n_rcv = {r_rcv[23:0], i_cmd.data_byte};
            end
            default: begin
            end
        endcase
        // The last word reports the frame and clears the checker state.
        if (i_cmd.last_byte) begin
            n_out.frame_done     = 1'b1;
            n_out.frame_ok       = i_cmd.len_ok && ((n_crc ^ CRC_INIT) == n_rcv);
            n_out.message_length = i_cmd.message_length;
            n_crc                = CRC_INIT;
            n_rcv                = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= CRC_INIT;
            r_rcv       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_crc       <= n_crc;
                r_rcv       <= n_rcv;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule
